// File: sv/thumb_alu_format1_to_4_executor_macros.svh
// Assertion macros for the Thumb ALU executor.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef THUMB_ALU_FORMAT1_TO_4_EXECUTOR_MACROS_SVH
`define THUMB_ALU_FORMAT1_TO_4_EXECUTOR_MACROS_SVH

// Same-cycle implication.
`define TAE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TAE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/tae_pkg.sv
// Shared types and constants of the Thumb ALU executor.
// Used by tae_exec and by the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tae_pkg;

	localparam int REG_COUNT = 8;
	localparam int REG_IDX_W = 3;

	// Format decode masks and match patterns.
	localparam logic [15:0] FMT_ADDSUB_MASK  = 16'hF800;
	localparam logic [15:0] FMT_ADDSUB_MATCH = 16'h1800;
	localparam logic [15:0] FMT_TOP3_MASK    = 16'hE000;
	localparam logic [15:0] FMT_SHIFT_MATCH  = 16'h0000;
	localparam logic [15:0] FMT_IMM8_MATCH   = 16'h2000;
	localparam logic [15:0] FMT_ALU_MASK     = 16'hFC00;
	localparam logic [15:0] FMT_ALU_MATCH    = 16'h4000;

	// Register ALU operation codes.
	localparam logic [3:0] ALU_AND = 4'h0;
	localparam logic [3:0] ALU_EOR = 4'h1;
	localparam logic [3:0] ALU_LSL = 4'h2;
	localparam logic [3:0] ALU_LSR = 4'h3;
	localparam logic [3:0] ALU_ASR = 4'h4;
	localparam logic [3:0] ALU_ADC = 4'h5;
	localparam logic [3:0] ALU_SBC = 4'h6;
	localparam logic [3:0] ALU_ROR = 4'h7;
	localparam logic [3:0] ALU_TST = 4'h8;
	localparam logic [3:0] ALU_NEG = 4'h9;
	localparam logic [3:0] ALU_CMP = 4'hA;
	localparam logic [3:0] ALU_CMN = 4'hB;
	localparam logic [3:0] ALU_ORR = 4'hC;
	localparam logic [3:0] ALU_MUL = 4'hD;
	localparam logic [3:0] ALU_BIC = 4'hE;
	localparam logic [3:0] ALU_MVN = 4'hF;

	// Immediate-8 format selectors.
	localparam logic [1:0] IMM_MOV = 2'd0;
	localparam logic [1:0] IMM_CMP = 2'd1;
	localparam logic [1:0] IMM_ADD = 2'd2;
	localparam logic [1:0] IMM_SUB = 2'd3;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

	typedef struct packed {
		logic                 wr;
		logic [REG_IDX_W-1:0] rd;
		logic [31:0]          value;
		flags_t               flags;
		logic                 undef;
	} exec_res_t;

endpackage

`default_nettype wire

// File: sv/tae_exec.sv
// Decode and execute logic for one Thumb instruction of formats 1 to 4.
// Pure combinational; uses types and codes from tae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tae_exec (
	input  logic [15:0]        instruction,
	input  logic [31:0]        a_val,     // value of Rs, bits 5:3
	input  logic [31:0]        b_val,     // Rn, Rd of the immediate format, or Rd
	input  tae_pkg::flags_t    flags_in,
	output tae_pkg::exec_res_t res
);
	import tae_pkg::*;

	typedef enum logic [1:0] {SH_LSL, SH_LSR, SH_ASR, SH_ROR} shift_kind_t;

	logic        is_addsub, is_shift, is_imm8, is_alu;
	logic [3:0]  alu_op;
	logic [1:0]  imm_sel;
	logic [7:0]  imm8;

	logic [31:0] add_x, add_y, add_y0, add_r;
	logic        add_cin, add_c, add_v;
	logic [32:0] add_sum;

	shift_kind_t sh_kind;
	logic [31:0] sh_val, sh_r;
	logic [7:0]  sh_amt;
	logic        sh_c;

	logic [31:0] mul_r;
	logic        upd_nz;

	assign is_addsub = (instruction & FMT_ADDSUB_MASK) == FMT_ADDSUB_MATCH;
	assign is_shift  = !is_addsub && ((instruction & FMT_TOP3_MASK) == FMT_SHIFT_MATCH);
	assign is_imm8   = (instruction & FMT_TOP3_MASK) == FMT_IMM8_MATCH;
	assign is_alu    = (instruction & FMT_ALU_MASK) == FMT_ALU_MATCH;
	assign alu_op    = instruction[9:6];
	assign imm_sel   = instruction[12:11];
	assign imm8      = instruction[7:0];

	// Operand selection for the shared adder and the shifter.
	always_comb begin
		add_x   = b_val;
		add_y0  = a_val;
		add_y   = a_val;
		add_cin = 1'b0;
		sh_kind = SH_LSL;
		sh_val  = b_val;
		sh_amt  = a_val[7:0];
		if (is_addsub) begin
			add_x  = a_val;
			add_y0 = instruction[10] ? {29'd0, instruction[8:6]} : b_val;
			if (instruction[9]) begin
				add_y   = ~add_y0;
				add_cin = 1'b1;
			end else begin
				add_y = add_y0;
			end
		end else if (is_imm8) begin
			add_y0 = {24'd0, imm8};
			if (imm_sel == IMM_ADD) begin
				add_y = add_y0;
			end else begin
				add_y   = ~add_y0;
				add_cin = 1'b1;
			end
		end else begin
			case (alu_op)
				ALU_ADC: begin
					add_cin = flags_in.c;
				end
				ALU_SBC: begin
					add_y   = ~a_val;
					add_cin = flags_in.c;
				end
				ALU_NEG: begin
					add_x   = 32'd0;
					add_y   = ~a_val;
					add_cin = 1'b1;
				end
				ALU_CMP: begin
					add_y   = ~a_val;
					add_cin = 1'b1;
				end
				default: begin
					add_cin = 1'b0;
				end
			endcase
		end

		if (is_shift) begin
			sh_kind = shift_kind_t'(instruction[12:11]);
			sh_val  = a_val;
			// An immediate of zero means 32 for the right shifts.
			if (instruction[10:6] == 5'd0 && sh_kind != SH_LSL)
				sh_amt = 8'd32;
			else
				sh_amt = {3'd0, instruction[10:6]};
		end else begin
			case (alu_op)
				ALU_LSR: sh_kind = SH_LSR;
				ALU_ASR: sh_kind = SH_ASR;
				ALU_ROR: sh_kind = SH_ROR;
				default: sh_kind = SH_LSL;
			endcase
		end
	end

	assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
	assign add_r   = add_sum[31:0];
	assign add_c   = add_sum[32];
	assign add_v   = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ add_r[31]);

	assign mul_r = b_val * a_val;

	// Barrel shifter with the ARM carry rules for zero, 32 and larger amounts.
	always_comb begin
		logic [32:0] lsl_t, lsr_t, asr_t;
		logic [63:0] ror_t;
		logic        big, is32;
		lsl_t = {1'b0, sh_val} << sh_amt[4:0];
		lsr_t = {sh_val, 1'b0} >> sh_amt[4:0];
		asr_t = 33'($signed({sh_val, 1'b0}) >>> sh_amt[4:0]);
		ror_t = {sh_val, sh_val} >> sh_amt[4:0];
		big   = sh_amt[7:5] != 3'd0;
		is32  = sh_amt == 8'd32;
		sh_r  = sh_val;
		sh_c  = flags_in.c;
		if (sh_amt != 8'd0) begin
			case (sh_kind)
				SH_LSL: begin
					if (!big) begin
						sh_r = lsl_t[31:0];
						sh_c = lsl_t[32];
					end else begin
						sh_r = 32'd0;
						sh_c = is32 & sh_val[0];
					end
				end
				SH_LSR: begin
					if (!big) begin
						sh_r = lsr_t[32:1];
						sh_c = lsr_t[0];
					end else begin
						sh_r = 32'd0;
						sh_c = is32 & sh_val[31];
					end
				end
				SH_ASR: begin
					if (!big) begin
						sh_r = asr_t[32:1];
						sh_c = asr_t[0];
					end else begin
						sh_r = {32{sh_val[31]}};
						sh_c = sh_val[31];
					end
				end
				default: begin
					sh_r = ror_t[31:0];
					sh_c = ror_t[31];
				end
			endcase
		end
	end

	// Result and flag selection.
	always_comb begin
		res       = '0;
		res.flags = flags_in;
		upd_nz    = 1'b0;
		if (is_addsub) begin
			res.wr      = 1'b1;
			res.rd      = instruction[2:0];
			res.value   = add_r;
			res.flags.c = add_c;
			res.flags.v = add_v;
			upd_nz      = 1'b1;
		end else if (is_shift) begin
			res.wr      = 1'b1;
			res.rd      = instruction[2:0];
			res.value   = sh_r;
			res.flags.c = sh_c;
			upd_nz      = 1'b1;
		end else if (is_imm8) begin
			res.rd = instruction[10:8];
			upd_nz = 1'b1;
			if (imm_sel == IMM_MOV) begin
				res.wr    = 1'b1;
				res.value = {24'd0, imm8};
			end else begin
				res.wr      = imm_sel != IMM_CMP;
				res.value   = add_r;
				res.flags.c = add_c;
				res.flags.v = add_v;
			end
		end else if (is_alu) begin
			res.wr = 1'b1;
			res.rd = instruction[2:0];
			upd_nz = 1'b1;
			case (alu_op)
				ALU_AND: res.value = b_val & a_val;
				ALU_EOR: res.value = b_val ^ a_val;
				ALU_TST: begin
					res.value = b_val & a_val;
					res.wr    = 1'b0;
				end
				ALU_ORR: res.value = b_val | a_val;
				ALU_MUL: res.value = mul_r;
				ALU_BIC: res.value = b_val & ~a_val;
				ALU_MVN: res.value = ~a_val;
				ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: begin
					res.value   = sh_r;
					res.flags.c = sh_c;
				end
				default: begin
					// ADC, SBC, NEG, CMP and CMN go through the adder.
					res.value   = add_r;
					res.flags.c = add_c;
					res.flags.v = add_v;
					res.wr      = (alu_op != ALU_CMP) && (alu_op != ALU_CMN);
				end
			endcase
		end else begin
			res.undef = 1'b1;
		end
		if (upd_nz) begin
			res.flags.n = res.value[31];
			res.flags.z = ~|res.value;
		end
	end

endmodule

`default_nettype wire

// File: sv/thumb_alu_format1_to_4_executor.sv
// Top level of the Thumb ALU executor: register file memory, execute stage, output register.
// Depends on tae_pkg, tae_exec and thumb_alu_format1_to_4_executor_macros.svh.
//
// Usage:
// The slave channel (s_tvalid, s_tready, s_tdata) takes one 16-bit Thumb opcode per item.
// The master channel (m_tvalid, m_tready, m_tdata, m_tuser) returns exactly one result
// item per opcode, in order. m_tdata carries reg_written, dest_index, result_value and
// the N, Z, C, V flags after the instruction; m_tuser carries the undefined-opcode mark.
// Throughput is one item per cycle unless the receiver stalls. The eight low registers
// live in a memory with two read ports that is read in the cycle an item is accepted and
// written back at the end of the execute cycle; a bypass register covers a read of the entry
// written at that same edge, so dependent instructions follow back to back with no bubble.
// An accepted item is held in the execute stage registers until it retires into the output
// register, which drives m_tvalid until the receiver takes the result.
// The single output register holds a finished result while the receiver stalls; the
// execute stage then holds its item, and s_tready drops once both are full. Nothing is
// lost or repeated under any pattern of stalls on either side.
// Reset clears the flags, the pipeline valid bits and one valid bit per register; a
// register that was not written since reset reads as zero, so no clearing pass is needed
// and items are accepted from the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module thumb_alu_format1_to_4_executor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] instruction
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [0] reg_written, [3:1] dest_index,
	                               // [35:4] result_value, [36] flag_n, [37] flag_z,
	                               // [38] flag_c, [39] flag_v
	output logic [0:0]  m_tuser    // [0] undefined_op
);
	import tae_pkg::*;

	// Register file memory; valid bits make unwritten entries read as zero.
	logic [31:0]          regs_mem [REG_COUNT];
	logic [REG_COUNT-1:0] valid_q;

	logic                 accept, commit;
	logic [REG_IDX_W-1:0] addr_a, addr_b;

	// Execute stage.
	logic                 valid_s1;
	logic [15:0]          instr_s1;
	logic [31:0]          rda_s1, rdb_s1, fwd_data_s1;
	logic                 oka_s1, okb_s1, fwda_s1, fwdb_s1;
	logic [31:0]          opa, opb;

	flags_t               flags_q;
	exec_res_t            res;

	logic                 we;
	logic [REG_IDX_W-1:0] wa;
	logic [31:0]          wd;

	// Output register.
	logic                 out_valid_q;
	exec_res_t            out_q;

	assign commit   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || commit;
	assign accept   = s_tvalid && s_tready;

	// Port A always reads Rs in bits 5:3. Port B reads Rd of the immediate format,
	// Rn of the add/sub format, or Rd in bits 2:0 otherwise.
	assign addr_a = s_tdata[5:3];
	always_comb begin
		if ((s_tdata & FMT_TOP3_MASK) == FMT_IMM8_MATCH)
			addr_b = s_tdata[10:8];
		else if ((s_tdata & FMT_ADDSUB_MASK) == FMT_ADDSUB_MATCH)
			addr_b = s_tdata[8:6];
		else
			addr_b = s_tdata[2:0];
	end

	assign we = commit && res.wr;
	assign wa = res.rd;
	assign wd = res.value;

	// Memory: two registered reads at acceptance, one write at retirement.
	always_ff @(posedge clk) begin
		if (accept) begin
			rda_s1      <= regs_mem[addr_a];
			rdb_s1      <= regs_mem[addr_b];
			fwd_data_s1 <= wd;
			instr_s1    <= s_tdata;
		end
		if (we)
			regs_mem[wa] <= wd;
	end

	// Control state, bypass selects and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			valid_s1    <= 1'b0;
			oka_s1      <= 1'b0;
			okb_s1      <= 1'b0;
			fwda_s1     <= 1'b0;
			fwdb_s1     <= 1'b0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				oka_s1  <= valid_q[addr_a];
				okb_s1  <= valid_q[addr_b];
				// The write at this edge is not yet visible in the read data.
				fwda_s1 <= we && (wa == addr_a);
				fwdb_s1 <= we && (wa == addr_b);
			end
			if (accept)
				valid_s1 <= 1'b1;
			else if (commit)
				valid_s1 <= 1'b0;
			if (we)
				valid_q[wa] <= 1'b1;
			if (commit)
				flags_q <= res.flags;
			if (commit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign opa = fwda_s1 ? fwd_data_s1 : (oka_s1 ? rda_s1 : 32'd0);
	assign opb = fwdb_s1 ? fwd_data_s1 : (okb_s1 ? rdb_s1 : 32'd0);

	tae_exec u_exec (
		.instruction (instr_s1),
		.a_val       (opa),
		.b_val       (opb),
		.flags_in    (flags_q),
		.res         (res)
	);

	always_ff @(posedge clk) begin
		if (commit)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.flags.v, out_q.flags.c, out_q.flags.z, out_q.flags.n,
	                   out_q.value, out_q.rd, out_q.wr};
	assign m_tuser  = out_q.undef;

`include "thumb_alu_format1_to_4_executor_macros.svh"

	`TAE_ASSERT_NOW(a_no_overwrite, out_valid_q && !m_tready, !commit, "result overwritten while stalled")
	`TAE_ASSERT_NOW(a_undef_no_write, commit && res.undef, !we && res.flags == flags_q, "undefined opcode changed state")
	`TAE_ASSERT_NEXT(a_valid_after_write, we, valid_q[$past(wa)], "written register not marked valid")
	`TAE_ASSERT_NEXT(a_flags_hold, !commit, $stable(flags_q), "flags changed without a retiring item")

endmodule

`default_nettype wire

// File: tb/tb_thumb_alu_format1_to_4_executor.sv
// Self-checking testbench for the Thumb ALU executor (formats 1 to 4).
// It depends on tae_pkg for the decode masks, operation codes and result types,
// and on the thumb_alu_format1_to_4_executor top level.
`timescale 1ns / 1ps

module tb_thumb_alu_format1_to_4_executor;
	import tae_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 5;
	localparam int RANDOM_ITEMS   = 570;
	localparam int IDLE_PCT       = 31;
	localparam int STEADY_FIRST   = 250;    // no idling on either side in this window
	localparam int STEADY_LAST    = 400;
	localparam int HOLD_AT_RESULT = 300;    // receiver holds off once, inside that window
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_AT       = 450;    // random item index that waits for an empty pipe
	localparam int TAIL_CYCLES    = 10;
	localparam int CYCLE_LIMIT    = 100000;
	localparam int PRINT_LIMIT    = 40;

	typedef enum logic [1:0] {SH_LSL, SH_LSR, SH_ASR, SH_ROR} shift_kind_t;

	// One queued opcode. after_drain makes the sender wait until every
	// predicted result has come back before it offers this item.
	typedef struct {
		logic [15:0] opcode;
		bit          after_drain;
	} opcode_slot_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;   // [15:0] instruction
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // [0] reg_written, [3:1] dest_index, [35:4] result_value,
	                              // [36] flag_n, [37] flag_z, [38] flag_c, [39] flag_v
	logic [0:0]  m_tuser;         // [0] undefined_op

	// Architectural state as the predictor sees it after every accepted item.
	logic [31:0]  arch_regs [REG_COUNT];
	flags_t       arch_flags;

	opcode_slot_t opcode_queue [$];
	exec_res_t    retire_queue [$];
	int           total_ops       = 0;
	int           ops_accepted    = 0;
	int           results_checked = 0;
	int           mismatch_count  = 0;
	int           cycle_count     = 0;
	int           hold_left       = 0;
	bit           hold_done       = 1'b0;

	thumb_alu_format1_to_4_executor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor of the execute stage.
	// ------------------------------------------------------------------

	function automatic void set_nz(input logic [31:0] value);
		arch_flags.n = value[31];
		arch_flags.z = (value == 32'd0);
	endfunction

	function automatic logic [31:0] add_flags(input logic [31:0] a, input logic [31:0] b,
			input logic carry_in);
		logic [32:0] sum;
		sum = {1'b0, a} + {1'b0, b} + {32'd0, carry_in};
		set_nz(sum[31:0]);
		arch_flags.c = sum[32];
		arch_flags.v = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
		return sum[31:0];
	endfunction

	// a - b - borrow; C is set when no borrow comes out of bit 31.
	function automatic logic [31:0] sub_flags(input logic [31:0] a, input logic [31:0] b,
			input logic borrow);
		logic [31:0] diff;
		diff = a - b - {31'd0, borrow};
		set_nz(diff);
		arch_flags.c = ({1'b0, a} >= ({1'b0, b} + {32'd0, borrow}));
		arch_flags.v = (a[31] ^ b[31]) & (a[31] ^ diff[31]);
		return diff;
	endfunction

	// Shift with the ARM carry rules. An amount of zero leaves value and C alone;
	// callers map the immediate LSR/ASR encodings of zero to 32 beforehand.
	function automatic logic [31:0] shift_flags(input shift_kind_t kind, input logic [31:0] v,
			input logic [7:0] amount);
		logic [31:0] r;
		int          k;
		int          s;
		r = v;
		s = amount;
		if (s == 0)
			return v;
		case (kind)
			SH_LSL: begin
				if (s < 32) begin
					arch_flags.c = v[32 - s];
					r = v << s;
				end else begin
					arch_flags.c = (s == 32) && v[0];
					r = '0;
				end
			end
			SH_LSR: begin
				if (s < 32) begin
					arch_flags.c = v[s - 1];
					r = v >> s;
				end else begin
					arch_flags.c = (s == 32) && v[31];
					r = '0;
				end
			end
			SH_ASR: begin
				// Beyond 31 the whole word fills with the sign.
				if (s < 32) begin
					arch_flags.c = v[s - 1];
					r = $signed(v) >>> s;
				end else begin
					arch_flags.c = v[31];
					r = {32{v[31]}};
				end
			end
			default: begin
				// A rotation by a multiple of 32 keeps the word and copies bit 31 to C.
				k = s % 32;
				if (k == 0) begin
					arch_flags.c = v[31];
				end else begin
					r = (v >> k) | (v << (32 - k));
					arch_flags.c = v[k - 1];
				end
			end
		endcase
		return r;
	endfunction

	// Executes one opcode on the mirrored state and returns the result item
	// the block has to produce for it.
	function automatic exec_res_t execute_thumb(input logic [15:0] op);
		exec_res_t   res;
		logic [31:0] a;
		logic [31:0] b;
		logic [7:0]  amount;
		res = '0;
		if ((op & FMT_ADDSUB_MASK) == FMT_ADDSUB_MATCH) begin
			// Three-operand add/sub; bit 10 picks the 3-bit immediate over Rn.
			res.rd = op[2:0];
			b = op[10] ? {29'd0, op[8:6]} : arch_regs[op[8:6]];
			res.value = op[9] ? sub_flags(arch_regs[op[5:3]], b, 1'b0)
			                  : add_flags(arch_regs[op[5:3]], b, 1'b0);
			res.wr = 1'b1;
		end else if ((op & FMT_TOP3_MASK) == FMT_SHIFT_MATCH) begin
			res.rd = op[2:0];
			amount = {3'd0, op[10:6]};
			if (op[12:11] != 2'd0 && amount == 8'd0)
				amount = 8'd32;
			res.value = shift_flags(shift_kind_t'(op[12:11]), arch_regs[op[5:3]], amount);
			set_nz(res.value);
			res.wr = 1'b1;
		end else if ((op & FMT_TOP3_MASK) == FMT_IMM8_MATCH) begin
			res.rd = op[10:8];
			a = arch_regs[op[10:8]];
			b = {24'd0, op[7:0]};
			res.wr = 1'b1;
			case (op[12:11])
				IMM_MOV: begin
					res.value = b;
					set_nz(res.value);
				end
				IMM_CMP: begin
					res.value = sub_flags(a, b, 1'b0);
					res.wr = 1'b0;
				end
				IMM_ADD: res.value = add_flags(a, b, 1'b0);
				default: res.value = sub_flags(a, b, 1'b0);
			endcase
		end else if ((op & FMT_ALU_MASK) == FMT_ALU_MATCH) begin
			res.rd = op[2:0];
			a = arch_regs[op[2:0]];
			b = arch_regs[op[5:3]];
			res.wr = 1'b1;
			case (op[9:6])
				ALU_AND: res.value = a & b;
				ALU_EOR: res.value = a ^ b;
				ALU_LSL: res.value = shift_flags(SH_LSL, a, b[7:0]);
				ALU_LSR: res.value = shift_flags(SH_LSR, a, b[7:0]);
				ALU_ASR: res.value = shift_flags(SH_ASR, a, b[7:0]);
				ALU_ADC: res.value = add_flags(a, b, arch_flags.c);
				ALU_SBC: res.value = sub_flags(a, b, ~arch_flags.c);
				ALU_ROR: res.value = shift_flags(SH_ROR, a, b[7:0]);
				ALU_TST: begin
					res.value = a & b;
					res.wr = 1'b0;
				end
				ALU_NEG: res.value = sub_flags(32'd0, b, 1'b0);
				ALU_CMP: begin
					res.value = sub_flags(a, b, 1'b0);
					res.wr = 1'b0;
				end
				ALU_CMN: begin
					res.value = add_flags(a, b, 1'b0);
					res.wr = 1'b0;
				end
				ALU_ORR: res.value = a | b;
				ALU_MUL: res.value = a * b;
				ALU_BIC: res.value = a & ~b;
				default: res.value = ~b;
			endcase
			// The logical operations, the register shifts and MUL set only N and Z here;
			// the arithmetic ones have already set all four flags.
			case (op[9:6])
				ALU_ADC, ALU_SBC, ALU_NEG, ALU_CMP, ALU_CMN: ;
				default: set_nz(res.value);
			endcase
		end else begin
			// Outside the four formats nothing changes and the item only carries the flags.
			res.undef = 1'b1;
		end
		if (res.wr)
			arch_regs[res.rd] = res.value;
		res.flags = arch_flags;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Opcode builders; the directed items use all of them, the random ones all but op_addsub.
	// ------------------------------------------------------------------

	function automatic logic [15:0] op_shift(input shift_kind_t kind, input logic [4:0] offset,
			input logic [2:0] rs, input logic [2:0] rd);
		return FMT_SHIFT_MATCH | {3'b000, kind, offset, rs, rd};
	endfunction

	function automatic logic [15:0] op_addsub(input logic is_sub, input logic is_imm,
			input logic [2:0] rn, input logic [2:0] rs, input logic [2:0] rd);
		return FMT_ADDSUB_MATCH | {5'd0, is_imm, is_sub, rn, rs, rd};
	endfunction

	function automatic logic [15:0] op_imm8(input logic [1:0] sel, input logic [2:0] rd,
			input logic [7:0] imm);
		return FMT_IMM8_MATCH | {3'b000, sel, rd, imm};
	endfunction

	function automatic logic [15:0] op_alu(input logic [3:0] alu, input logic [2:0] rs,
			input logic [2:0] rd);
		return FMT_ALU_MATCH | {6'd0, alu, rs, rd};
	endfunction

	// Random opcode mix. Most items are well-formed instructions of the four
	// formats with random registers; MOVs often load the shift-amount edges
	// (0, 1, 31, 32, 33, 40, 128, 255) so the register shifts hit the ARM
	// corner rules, and one item in ten is a raw 16-bit word, which also
	// exercises the undefined opcodes and every bit of the instruction.
	function automatic logic [15:0] random_opcode();
		logic [7:0] shift_edges [8];
		int         pick;
		shift_edges = '{8'd0, 8'd1, 8'd31, 8'd32, 8'd33, 8'd40, 8'd128, 8'd255};
		pick = $urandom_range(99);
		if (pick < 10)
			return op_imm8(IMM_MOV, 3'($urandom_range(7)), shift_edges[$urandom_range(7)]);
		else if (pick < 25)
			return op_shift(shift_kind_t'($urandom_range(2)),
				($urandom_range(3) == 0) ? 5'd0 : 5'($urandom_range(31)),
				3'($urandom_range(7)), 3'($urandom_range(7)));
		else if (pick < 40)
			return FMT_ADDSUB_MATCH | 16'($urandom_range(16'h07FF));
		else if (pick < 55)
			return FMT_IMM8_MATCH | 16'($urandom_range(16'h1FFF));
		else if (pick < 90)
			return op_alu(4'($urandom_range(15)), 3'($urandom_range(7)), 3'($urandom_range(7)));
		else
			return 16'($urandom);
	endfunction

	task automatic queue_opcode(input logic [15:0] op, input bit after_drain);
		opcode_slot_t slot;
		slot.opcode = op;
		slot.after_drain = after_drain;
		opcode_queue.push_back(slot);
		total_ops++;
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Sender: offers queued opcodes, predicts each item as it is accepted.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		opcode_slot_t next_slot;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				// Push before counting so the end check never sees the count ahead.
				retire_queue.push_back(execute_thumb(s_tdata));
				ops_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (opcode_queue.size() != 0
						&& !(opcode_queue[0].after_drain && retire_queue.size() != 0)
						&& ((ops_accepted >= STEADY_FIRST && ops_accepted < STEADY_LAST)
							|| $urandom_range(99) >= IDLE_PCT)) begin
					next_slot = opcode_queue.pop_front();
					s_tdata <= next_slot.opcode;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: checks each accepted result against the oldest prediction
	// and drives m_tready, including one long hold-off that backs the
	// pipeline up until s_tready drops.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		exec_res_t got;
		exec_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[3:1], m_tdata[35:4],
				       m_tdata[36], m_tdata[37], m_tdata[38], m_tdata[39], m_tuser[0]};
				if (retire_queue.size() == 0) begin
					report_mismatch($sformatf("result with no item pending: tdata=%h tuser=%b",
						m_tdata, m_tuser));
				end else begin
					want = retire_queue.pop_front();
					if (got.wr !== want.wr)
						report_mismatch($sformatf("result %0d reg_written %b, want %b",
							results_checked, got.wr, want.wr));
					if (got.rd !== want.rd)
						report_mismatch($sformatf("result %0d dest_index %0d, want %0d",
							results_checked, got.rd, want.rd));
					if (got.value !== want.value)
						report_mismatch($sformatf("result %0d result_value %h, want %h",
							results_checked, got.value, want.value));
					if (got.flags.n !== want.flags.n)
						report_mismatch($sformatf("result %0d flag_n %b, want %b",
							results_checked, got.flags.n, want.flags.n));
					if (got.flags.z !== want.flags.z)
						report_mismatch($sformatf("result %0d flag_z %b, want %b",
							results_checked, got.flags.z, want.flags.z));
					if (got.flags.c !== want.flags.c)
						report_mismatch($sformatf("result %0d flag_c %b, want %b",
							results_checked, got.flags.c, want.flags.c));
					if (got.flags.v !== want.flags.v)
						report_mismatch($sformatf("result %0d flag_v %b, want %b",
							results_checked, got.flags.v, want.flags.v));
					if (got.undef !== want.undef)
						report_mismatch($sformatf("result %0d undefined_op %b, want %b",
							results_checked, got.undef, want.undef));
				end
				results_checked++;
			end

			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && results_checked == HOLD_AT_RESULT) begin
				// The sender is in its no-idle window here, so it keeps offering.
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (results_checked >= STEADY_FIRST && results_checked < STEADY_LAST) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog for a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------
	initial begin
		foreach (arch_regs[i])
			arch_regs[i] = '0;
		arch_flags = '0;

		// Directed items. The first is the all-zero word, LSL r0,r0,#0: a plain move
		// that keeps C. The MOVs load 255, 32 and 40 for the shift corner cases.
		queue_opcode(op_shift(SH_LSL, 5'd0, 3'd0, 3'd0), 1'b0);
		queue_opcode(op_imm8(IMM_MOV, 3'd0, 8'd255), 1'b0);
		queue_opcode(op_imm8(IMM_MOV, 3'd1, 8'd32), 1'b0);
		queue_opcode(op_imm8(IMM_MOV, 3'd2, 8'd40), 1'b0);
		queue_opcode(op_shift(SH_LSL, 5'd24, 3'd0, 3'd3), 1'b0);   // r3 = 0xFF000000
		// Immediate LSR and ASR by zero act as a shift by 32.
		queue_opcode(op_shift(SH_LSR, 5'd0, 3'd3, 3'd4), 1'b0);
		queue_opcode(op_shift(SH_ASR, 5'd0, 3'd3, 3'd5), 1'b0);
		// Register shifts by exactly 32 and beyond 32, and a rotation by 32.
		queue_opcode(op_alu(ALU_LSL, 3'd1, 3'd0), 1'b0);
		queue_opcode(op_alu(ALU_LSR, 3'd2, 3'd3), 1'b0);
		queue_opcode(op_alu(ALU_ASR, 3'd2, 3'd5), 1'b0);
		queue_opcode(op_alu(ALU_ROR, 3'd1, 3'd5), 1'b0);
		// Compare and test only touch the flags.
		queue_opcode(op_alu(ALU_TST, 3'd5, 3'd5), 1'b0);
		queue_opcode(op_alu(ALU_CMP, 3'd2, 3'd1), 1'b0);
		queue_opcode(op_alu(ALU_CMN, 3'd1, 3'd5), 1'b0);
		queue_opcode(op_alu(ALU_NEG, 3'd2, 3'd6), 1'b0);
		queue_opcode(op_alu(ALU_ADC, 3'd5, 3'd6), 1'b0);
		queue_opcode(op_alu(ALU_SBC, 3'd1, 3'd6), 1'b0);
		// MUL keeps C and V from the SBC before it.
		queue_opcode(op_alu(ALU_MUL, 3'd2, 3'd1), 1'b0);
		queue_opcode(op_alu(ALU_AND, 3'd5, 3'd6), 1'b0);
		queue_opcode(op_alu(ALU_EOR, 3'd1, 3'd6), 1'b0);
		queue_opcode(op_alu(ALU_ORR, 3'd6, 3'd7), 1'b0);
		queue_opcode(op_alu(ALU_BIC, 3'd1, 3'd7), 1'b0);
		queue_opcode(op_alu(ALU_MVN, 3'd0, 3'd7), 1'b0);
		queue_opcode(op_imm8(IMM_CMP, 3'd1, 8'd255), 1'b0);
		queue_opcode(op_imm8(IMM_ADD, 3'd2, 8'd255), 1'b0);
		queue_opcode(op_imm8(IMM_SUB, 3'd2, 8'd255), 1'b0);
		queue_opcode(op_addsub(1'b0, 1'b0, 3'd2, 3'd1, 3'd3), 1'b0);
		queue_opcode(op_addsub(1'b1, 1'b1, 3'd7, 3'd1, 3'd4), 1'b0);
		// The all-ones word is outside every format.
		queue_opcode(16'hFFFF, 1'b0);

		// Random items. The first one and one later on wait for an empty pipe.
		for (int i = 0; i < RANDOM_ITEMS; i++)
			queue_opcode(random_opcode(), (i == 0) || (i == DRAIN_AT));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_accepted < total_ops || retire_queue.size() != 0)
			@(posedge clk);
		// Keep the clock running so that a stray extra result would still be seen.
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/tae_pkg.sv
sv/tae_exec.sv
sv/thumb_alu_format1_to_4_executor.sv
tb/tb_thumb_alu_format1_to_4_executor.sv
